// File: rtl/vfcm_pkg.sv
// Package for the voxel face culling mesher.
// Holds command and face codes, stream widths and the corner table; no dependencies.
`timescale 1ns / 1ps
package vfcm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_MESH  = 2'd3
  } cmd_e;

  localparam logic [2:0] FACE_PZ = 3'd0;
  localparam logic [2:0] FACE_NZ = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PX = 3'd4;
  localparam logic [2:0] FACE_NX = 3'd5;

  localparam logic CFG_VOXEL_SIZE = 1'b0;
  localparam logic CFG_OPAQUE_THR = 1'b1;

  localparam int CFG_W    = 11;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 104;
  localparam int COORD_W  = 17;
  localparam int VNUM_W   = 19;
  localparam int CIDX_W   = 15;

  // Corner signs per face and corner: bit 2 is x, bit 1 is y, bit 0 is z; set means plus.
  localparam logic [2:0] CORNER_POS [6][4] = '{
    '{3'b011, 3'b001, 3'b101, 3'b111},
    '{3'b100, 3'b000, 3'b010, 3'b110},
    '{3'b111, 3'b110, 3'b010, 3'b011},
    '{3'b001, 3'b000, 3'b100, 3'b101},
    '{3'b101, 3'b100, 3'b110, 3'b111},
    '{3'b011, 3'b010, 3'b000, 3'b001}
  };

endpackage

// File: rtl/vfcm_voxel_mem.sv
// Single-port-write, single-port-read voxel memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vfcm_voxel_mem #(
  parameter int DEPTH  = 20736,
  parameter int ADDR_W = 15
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vfcm_mul.sv
// Shared registered multiplier used for the three cell centre coordinates.
// Depends on vfcm_pkg for the coordinate width.
`timescale 1ns / 1ps
module vfcm_mul (
  input  logic                          clk_i,
  input  logic [5:0]                    a_i,
  input  logic [10:0]                   b_i,
  output logic [vfcm_pkg::COORD_W-1:0]  p_o
);
  import vfcm_pkg::*;

  logic [COORD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= COORD_W'(a_i) * COORD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/voxel_face_culling_mesher_top.sv
// Top level of the voxel face culling mesher: sequencer, configuration and output register.
// Depends on vfcm_pkg, vfcm_voxel_mem and vfcm_mul.
// After reset the voxel memory is cleared one cell a cycle, all (LINE+2)^2*HEIGHT cells,
// while no request is taken. A write or start passes through a dispatch state before the
// next request is taken; a read in the grid returns the registered memory data, one outside
// it returns zeros. A mesh runs the centre read, the multiplier steps and six neighbour reads
// (an issue and a wait each through the single read port, none past the top or bottom), then
// a scan of the faces and one vertex result per cycle while the sink is ready.
`timescale 1ns / 1ps
module voxel_face_culling_mesher_top #(
  parameter int LINE     = 16,
  parameter int HEIGHT   = 64,
  parameter int SECTIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [vfcm_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cell_x, cell_y, cell_z, new_value
  input  logic [vfcm_pkg::IN_W-1:0]     s_axis_tdata,
  // command
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // vertex_x, vertex_y, vertex_z, face_dir, section, vertex_number, cell_value,
  // cell_index, four zero bits
  output logic [vfcm_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast
);
  import vfcm_pkg::*;

  localparam int EXT    = LINE + 2;
  localparam int PLANE  = EXT * EXT;
  localparam int CELLS  = PLANE * HEIGHT;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RD_WAIT, S_CTR_WAIT, S_MUL,
    S_NB_ISSUE, S_NB_WAIT, S_SCAN, S_RESULT
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0] clr_q;
  logic [10:0] vsize_q;
  logic signed [7:0] thr_q;
  cmd_e cmd_q;
  logic [4:0] x_q, y_q;
  logic [5:0] z_q;
  logic [7:0] val_q;
  logic [SEC_W-1:0] sec_q;
  logic [1:0] step_q, k_q;
  logic [2:0] d_q;
  logic [5:0] mask_q;
  logic [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [VNUM_W-1:0] ctr_q [SECTIONS];
  logic is_read_q;

  logic out_valid_q, last_q;
  logic [COORD_W-1:0] vx_q, vy_q, vz_q;
  logic [2:0] face_q;
  logic [3:0] secout_q;
  logic [VNUM_W-1:0] vn_q;
  logic [7:0] cv_q;
  logic [CIDX_W-1:0] ci_q;

  logic accept, in_grid, interior;
  logic [IDX_W-1:0] idx, nb_addr, raddr, waddr;
  logic mem_we;
  logic [7:0] wdata, rdata;
  logic [5:0] mul_a;
  logic [COORD_W-1:0] prod, half;
  logic [1:0] load_k;
  logic [2:0] pos;
  logic [COORD_W-1:0] px, py, pz;
  logic face_final;
  logic signed [7:0] rval;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_grid  = (int'(x_q) < EXT) && (int'(y_q) < EXT) && (int'(z_q) < HEIGHT);
  assign interior = in_grid && (x_q != 5'd0) && (int'(x_q) <= LINE) &&
                    (y_q != 5'd0) && (int'(y_q) <= LINE);
  assign idx = IDX_W'(x_q) + IDX_W'(y_q) * IDX_W'(EXT) + IDX_W'(z_q) * IDX_W'(PLANE);
  assign rval = signed'(rdata);

  always_comb begin
    case (d_q)
      FACE_PZ: nb_addr = idx + IDX_W'(PLANE);
      FACE_NZ: nb_addr = idx - IDX_W'(PLANE);
      FACE_PY: nb_addr = idx + IDX_W'(EXT);
      FACE_NY: nb_addr = idx - IDX_W'(EXT);
      FACE_PX: nb_addr = idx + IDX_W'(1);
      default: nb_addr = idx - IDX_W'(1);
    endcase
  end

  assign raddr  = (state_q == S_NB_ISSUE) ? nb_addr : idx;
  assign mem_we = (state_q == S_CLEAR) ||
                  (state_q == S_DISPATCH && cmd_q == CMD_WRITE && in_grid);
  assign waddr  = (state_q == S_CLEAR) ? clr_q : idx;
  assign wdata  = (state_q == S_CLEAR) ? 8'd0 : val_q;

  vfcm_voxel_mem #(.DEPTH(CELLS), .ADDR_W(IDX_W)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (step_q)
      2'd0:    mul_a = 6'(x_q - 5'd1);
      2'd1:    mul_a = 6'(y_q - 5'd1);
      default: mul_a = z_q;
    endcase
  end

  vfcm_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(vsize_q), .p_o(prod));

  // Vertex for the corner about to be loaded into the output register.
  assign half   = COORD_W'(vsize_q[10:1]);
  assign load_k = (state_q == S_SCAN) ? 2'd0 : k_q + 2'd1;
  assign pos    = CORNER_POS[d_q][load_k];
  assign px     = pos[2] ? cx_q + half : cx_q - half;
  assign py     = pos[1] ? cy_q + half : cy_q - half;
  assign pz     = pos[0] ? cz_q + half : cz_q - half;
  assign face_final = ((mask_q >> (d_q + 3'd1)) == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      vsize_q     <= 11'd100;
      thr_q       <= 8'sd10;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        ctr_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VOXEL_SIZE: vsize_q <= cfg_data_i;
          CFG_OPAQUE_THR: thr_q   <= signed'(cfg_data_i[7:0]);
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (int'(clr_q) == CELLS - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_e'(s_axis_tuser);
            x_q     <= s_axis_tdata[4:0];
            y_q     <= s_axis_tdata[9:5];
            z_q     <= s_axis_tdata[15:10];
            val_q   <= s_axis_tdata[23:16];
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (cmd_q)
            CMD_WRITE: state_q <= S_IDLE;
            CMD_START: begin
              for (int i = 0; i < SECTIONS; i++) begin
                ctr_q[i] <= '0;
              end
              state_q <= S_IDLE;
            end
            CMD_READ: begin
              is_read_q <= 1'b1;
              if (in_grid) begin
                state_q <= S_RD_WAIT;
              end else begin
                vx_q <= '0; vy_q <= '0; vz_q <= '0; face_q <= '0;
                secout_q <= '0; vn_q <= '0; cv_q <= '0; ci_q <= '0;
                last_q <= 1'b1; out_valid_q <= 1'b1;
                state_q <= S_RESULT;
              end
            end
            default: begin
              is_read_q <= 1'b0;
              state_q   <= interior ? S_CTR_WAIT : S_IDLE;
            end
          endcase
        end
        S_RD_WAIT: begin
          vx_q <= '0; vy_q <= '0; vz_q <= '0; face_q <= '0;
          secout_q <= '0; vn_q <= '0;
          cv_q <= rdata; ci_q <= CIDX_W'(idx);
          last_q <= 1'b1; out_valid_q <= 1'b1;
          state_q <= S_RESULT;
        end
        S_CTR_WAIT: begin
          if (rval > 8'sd0 && int'(rval) <= SECTIONS) begin
            sec_q   <= SEC_W'(rval - 8'sd1);
            step_q  <= 2'd0;
            state_q <= S_MUL;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_MUL: begin
          step_q <= step_q + 2'd1;
          case (step_q)
            2'd1:    cx_q <= prod;
            2'd2:    cy_q <= prod;
            2'd3:    cz_q <= prod;
            default: ;
          endcase
          if (step_q == 2'd3) begin
            d_q     <= FACE_PZ;
            state_q <= S_NB_ISSUE;
          end
        end
        S_NB_ISSUE: begin
          // No face past the top or the bottom of the grid.
          if ((d_q == FACE_PZ && int'(z_q) == HEIGHT - 1) ||
              (d_q == FACE_NZ && z_q == 6'd0)) begin
            mask_q[d_q] <= 1'b0;
            d_q         <= d_q + 3'd1;
          end else begin
            state_q <= S_NB_WAIT;
          end
        end
        S_NB_WAIT: begin
          mask_q[d_q] <= (rval < thr_q);
          if (d_q == FACE_NX) begin
            d_q     <= FACE_PZ;
            state_q <= S_SCAN;
          end else begin
            d_q     <= d_q + 3'd1;
            state_q <= S_NB_ISSUE;
          end
        end
        S_SCAN: begin
          if (mask_q[d_q]) begin
            k_q <= 2'd0;
            vx_q <= px; vy_q <= py; vz_q <= pz; face_q <= d_q;
            secout_q <= 4'(sec_q); vn_q <= ctr_q[sec_q];
            cv_q <= '0; ci_q <= '0;
            last_q <= 1'b0; out_valid_q <= 1'b1;
            state_q <= S_RESULT;
          end else if (d_q == FACE_NX) begin
            state_q <= S_IDLE;
          end else begin
            d_q <= d_q + 3'd1;
          end
        end
        S_RESULT: begin
          if (m_axis_tready) begin
            if (is_read_q) begin
              out_valid_q <= 1'b0;
              state_q     <= S_IDLE;
            end else if (k_q == 2'd3) begin
              out_valid_q  <= 1'b0;
              ctr_q[sec_q] <= ctr_q[sec_q] + VNUM_W'(4);
              if (face_final || d_q == FACE_NX) begin
                state_q <= S_IDLE;
              end else begin
                d_q     <= d_q + 3'd1;
                state_q <= S_SCAN;
              end
            end else begin
              k_q <= load_k;
              vx_q <= px; vy_q <= py; vz_q <= pz;
              vn_q <= ctr_q[sec_q] + VNUM_W'(load_k);
              last_q <= (load_k == 2'd3) && face_final;
              out_valid_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {4'd0, ci_q, cv_q, vn_q, secout_q, face_q, vz_q, vy_q, vx_q};

endmodule

// File: rtl/vfcm_checker.sv
// Port-level checks for the voxel face culling mesher, bound to the top level.
// Depends on vfcm_pkg and voxel_face_culling_mesher_top.
`timescale 1ns / 1ps
module vfcm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [vfcm_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast
);
  import vfcm_pkg::*;

  // A result waiting on the sink holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The block works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("request taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after a request");

  // Results of a request only end with tlast before the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("block went idle before the final result");

endmodule

bind voxel_face_culling_mesher_top vfcm_checker u_vfcm_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the voxel face culling mesher top level.
// Depends on vfcm_pkg and voxel_face_culling_mesher_top; a scoreboard class predicts vertices.
`timescale 1ns / 1ps
module testbench;
  import vfcm_pkg::*;

  localparam int EXT   = 18;
  localparam int PLANE = EXT * EXT;
  localparam int CELLS = PLANE * 64;

  // Corner signs per face and corner, x, y, z.
  localparam int CSIGN [6][4][3] = '{
    '{'{-1, 1, 1}, '{-1, -1, 1}, '{1, -1, 1}, '{1, 1, 1}},
    '{'{1, -1, -1}, '{-1, -1, -1}, '{-1, 1, -1}, '{1, 1, -1}},
    '{'{1, 1, 1}, '{1, 1, -1}, '{-1, 1, -1}, '{-1, 1, 1}},
    '{'{-1, -1, 1}, '{-1, -1, -1}, '{1, -1, -1}, '{1, -1, 1}},
    '{'{1, -1, 1}, '{1, -1, -1}, '{1, 1, -1}, '{1, 1, 1}},
    '{'{-1, 1, 1}, '{-1, 1, -1}, '{-1, -1, -1}, '{-1, -1, 1}}
  };
  localparam int DSTEP [6][3] = '{
    '{0, 0, 1}, '{0, 0, -1}, '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}
  };

  typedef struct {
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic signed [16:0] vz;
    logic [2:0]         dir;
    logic [3:0]         sec;
    logic [18:0]        vnum;
    logic signed [7:0]  val;
    logic [14:0]        idx;
    logic               last;
  } mesh_out_t;

  class mesh_scoreboard;
    logic signed [7:0] grid [CELLS];
    logic [18:0]       counters [16];
    int                vsize;
    logic signed [7:0] thr;
    mesh_out_t         expected_q [$];
    int                errors;

    function new();
      foreach (grid[i]) grid[i] = 0;
      foreach (counters[i]) counters[i] = 0;
      vsize  = 100;
      thr    = 10;
      errors = 0;
    endfunction

    function void note_request(cmd_e cmd, int x, int y, int z, logic signed [7:0] v);
      mesh_out_t r;
      int idx, n, nidx, nz, half, px, py, pz;
      logic signed [7:0] cv;
      logic [3:0] sec;
      bit in_grid;
      in_grid = x < EXT && y < EXT && z < 64;
      idx = x + y * EXT + z * PLANE;
      r = '{default: '0};
      case (cmd)
        CMD_WRITE: if (in_grid) grid[idx] = v;
        CMD_START: foreach (counters[i]) counters[i] = 0;
        CMD_READ: begin
          if (in_grid) begin
            r.val = grid[idx];
            r.idx = idx[14:0];
          end
          r.last = 1'b1;
          expected_q.push_back(r);
        end
        CMD_MESH: begin
          if (!in_grid || x < 1 || x > 16 || y < 1 || y > 16) return;
          cv = grid[idx];
          if (cv < 1 || cv > 16) return;
          sec  = 4'(cv - 1);
          half = vsize >> 1;
          n    = 0;
          for (int d = 0; d < 6; d++) begin
            nz = z + DSTEP[d][2];
            if (nz < 0 || nz > 63) continue;
            nidx = (x + DSTEP[d][0]) + (y + DSTEP[d][1]) * EXT + nz * PLANE;
            if (grid[nidx] >= thr) continue;
            for (int k = 0; k < 4; k++) begin
              px = (x - 1) * vsize + CSIGN[d][k][0] * half;
              py = (y - 1) * vsize + CSIGN[d][k][1] * half;
              pz = z * vsize + CSIGN[d][k][2] * half;
              r.vx   = px[16:0];
              r.vy   = py[16:0];
              r.vz   = pz[16:0];
              r.dir  = 3'(d);
              r.sec  = sec;
              r.vnum = counters[sec] + 19'(k);
              r.last = 1'b0;
              expected_q.push_back(r);
              n++;
            end
            counters[sec] = counters[sec] + 19'd4;
          end
          if (n > 0) expected_q[$].last = 1'b1;
        end
      endcase
    endfunction

    function void cmp_field(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] d, logic l);
      mesh_out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: data %h last %b", d, l);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("vertex_x", e.vx, $signed(d[16:0]));
      cmp_field("vertex_y", e.vy, $signed(d[33:17]));
      cmp_field("vertex_z", e.vz, $signed(d[50:34]));
      cmp_field("face_dir", e.dir, d[53:51]);
      cmp_field("section", e.sec, d[57:54]);
      cmp_field("vertex_number", e.vnum, d[76:58]);
      cmp_field("cell_value", e.val, $signed(d[84:77]));
      cmp_field("cell_index", e.idx, d[99:85]);
      cmp_field("last", e.last, l);
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [OUT_W-1:0] m_axis_tdata;

  mesh_scoreboard sb;
  int  hold_cycles = 0;
  bit  no_idle = 0;
  int  items_sent = 0;

  voxel_face_culling_mesher_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic send_req(cmd_e c, int x, int y, int z, int v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {8'(v), 6'(z), 5'(y), 5'(x)};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(c, x & 31, y & 31, z & 63, 8'(v));
    items_sent++;
  endtask

  // Waits until every expected result is in, then lets a mesh scan run out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_VOXEL_SIZE) sb.vsize = value & 11'h7FF;
    else sb.thr = 8'(value);
  endtask

  // Mostly a filled cell with random neighbours that is then meshed; the rest is noise.
  task automatic random_traffic(int count);
    int x, y, z, pick, stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        x = $urandom_range(1, 16);
        y = $urandom_range(1, 16);
        z = $urandom_range(0, 63);
        send_req(CMD_WRITE, x, y, z,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 16));
        repeat ($urandom_range(0, 3)) begin
          pick = $urandom_range(0, 5);
          send_req(CMD_WRITE, x + DSTEP[pick][0], y + DSTEP[pick][1],
                   (z + DSTEP[pick][2]) & 63, $urandom_range(0, 255));
        end
        send_req(CMD_MESH, x, y, z, $urandom_range(0, 255));
      end else if (pick < 75) begin
        send_req(CMD_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 63), $urandom_range(0, 255));
      end else if (pick < 85) begin
        send_req(CMD_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 63), $urandom_range(0, 255));
      end else if (pick < 95) begin
        send_req(CMD_MESH, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 63), $urandom_range(0, 255));
      end else begin
        send_req(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 63), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_WRITE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings.
    send_req(CMD_WRITE, 1, 1, 0, 1);
    send_req(CMD_WRITE, 1, 1, 1, 127);
    send_req(CMD_MESH, 1, 1, 0, 0);        // bottom layer: no face below
    send_req(CMD_WRITE, 16, 16, 63, 16);
    send_req(CMD_MESH, 16, 16, 63, 0);     // top layer: no face above
    send_req(CMD_READ, 1, 1, 0, 0);
    send_req(CMD_READ, 17, 17, 63, 0);
    send_req(CMD_WRITE, 31, 3, 3, 5);      // outside the grid: ignored
    send_req(CMD_READ, 31, 31, 63, 0);
    send_req(CMD_MESH, 0, 5, 5, 0);        // border cell
    send_req(CMD_WRITE, 5, 5, 5, 17);
    send_req(CMD_MESH, 5, 5, 5, 0);        // value above the section count
    send_req(CMD_WRITE, 6, 6, 6, -128);
    send_req(CMD_MESH, 6, 6, 6, 0);
    send_req(CMD_MESH, 7, 7, 7, 0);        // empty cell
    for (int d = 0; d < 6; d++)
      send_req(CMD_WRITE, 8 + DSTEP[d][0], 8 + DSTEP[d][1], 8 + DSTEP[d][2], 127);
    send_req(CMD_WRITE, 8, 8, 8, 3);
    send_req(CMD_MESH, 8, 8, 8, 0);        // fully enclosed: no face
    send_req(CMD_START, 0, 0, 0, 0);
    send_req(CMD_MESH, 1, 1, 0, 0);

    // Settings phases, extremes first.
    wait_idle();
    write_cfg(CFG_VOXEL_SIZE, 1024);
    write_cfg(CFG_OPAQUE_THR, 127);
    random_traffic(100);
    wait_idle();
    write_cfg(CFG_VOXEL_SIZE, 2);
    write_cfg(CFG_OPAQUE_THR, -128);
    random_traffic(60);
    wait_idle();
    write_cfg(CFG_VOXEL_SIZE, 100);
    write_cfg(CFG_OPAQUE_THR, 10);
    // Long hold-off on the result side while requests keep coming.
    hold_cycles = 400;
    no_idle = 1;
    random_traffic(40);
    no_idle = 0;
    random_traffic(60);
    wait_idle();
    write_cfg(CFG_VOXEL_SIZE, 2 * $urandom_range(1, 512));
    write_cfg(CFG_OPAQUE_THR, $urandom_range(0, 255));
    random_traffic(100);
    wait_idle();
    write_cfg(CFG_VOXEL_SIZE, 682);
    write_cfg(CFG_OPAQUE_THR, 1);
    random_traffic(70);

    wait_idle();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
